// ----- src/lruc_pkg.sv -----
// lruc_pkg: shared types and codes for the lru cache with ttl expiry
// used by lruc_cell and lru_cache_with_ttl_expiry
package lruc_pkg;

  localparam int OP_BITS    = 2;
  localparam int ST_BITS    = 2;
  localparam int TIME_BITS  = 32;
  localparam int LIMIT_BITS = 5;
  localparam int OCC_BITS   = 5;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_EXPIRE = 2'd3
  } op_t;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LIMIT = 2'd0,
    REG_TTL   = 2'd1
  } reg_idx_t;

  // what every cell of the row does under the current command
  typedef enum logic [2:0] {
    ACT_HOLD    = 3'd0,
    ACT_PROMOTE = 3'd1,
    ACT_PUSH    = 3'd2,
    ACT_PULL    = 3'd3,
    ACT_DROP    = 3'd4
  } act_t;

  typedef struct packed {
    act_t act;
    logic evict;
  } cell_cmd_t;

endpackage

// ----- src/lru_cache_with_ttl_expiry.sv -----
// lru cache with ttl expiry: a row of lruc_cell entries kept in recency order
// insert, search and delete pass S_LOOK, which registers the key match, then S_EXEC,
// which registers the result; expire drops expired tail entries in S_EXP one at a time
// before its result; a new item is taken only in S_IDLE, so one item is in flight
// the output register lets the next item enter while a result waits
// reset (rst_n, synchronous): cache empty, entry limit 16, ttl 3600
// depends on lruc_pkg and lruc_cell
module lru_cache_with_ttl_expiry #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lruc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lruc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lruc_pkg::OP_BITS-1:0]       in_operation,
  input  logic [KEY_BITS-1:0]                in_key,
  input  logic [VALUE_BITS-1:0]              in_value,
  input  logic [lruc_pkg::TIME_BITS-1:0]     in_now,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lruc_pkg::ST_BITS-1:0]       out_status,
  output logic [VALUE_BITS-1:0]              out_value_out,
  output logic                               out_evicted,
  output logic [lruc_pkg::OCC_BITS-1:0]      out_removed_count,
  output logic [lruc_pkg::OCC_BITS-1:0]      out_occupancy
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LB = lruc_pkg::LIMIT_BITS;
  localparam int LW = (CW > LB) ? CW : LB;
  localparam int OW = lruc_pkg::OCC_BITS;
  localparam int TW = lruc_pkg::TIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_EXP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [LB-1:0]         lim_cfg_r;
  logic [TW-1:0]         ttl_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         removed_r, removed_nxt;

  lruc_pkg::op_t         op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [TW-1:0]         now_r;
  logic                  hit_r;
  logic [IW-1:0]         pos_r;
  logic [VALUE_BITS-1:0] hval_r;

  logic                  out_valid_r, out_valid_nxt;
  lruc_pkg::status_t     status_r, status_nxt;
  logic [VALUE_BITS-1:0] vout_r, vout_nxt;
  logic                  evicted_r, evicted_nxt;
  logic [OW-1:0]         rem_out_r, rem_out_nxt;
  logic [OW-1:0]         occ_r, occ_nxt;

  lruc_pkg::cell_cmd_t   cmd;
  logic [VALUE_BITS-1:0] head_val;
  logic [LW-1:0]         limit;
  logic                  full;
  logic                  out_free;
  logic                  take_in;

  logic [KEY_BITS-1:0]   c_key   [CAPACITY];
  logic [VALUE_BITS-1:0] c_val   [CAPACITY];
  logic [TW-1:0]         c_stamp [CAPACITY];
  logic                  c_valid [CAPACITY];
  logic                  c_tail  [CAPACITY];
  logic                  c_match [CAPACITY];
  logic                  c_exp   [CAPACITY];

  logic                  any_hit;
  logic [IW-1:0]         hit_pos;
  logic [VALUE_BITS-1:0] hit_val;
  logic                  tail_exp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign take_in   = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_value_out     = vout_r;
  assign out_evicted       = evicted_r;
  assign out_removed_count = rem_out_r;
  assign out_occupancy     = occ_r;

  // zero acts as one, anything above the row length as the row length
  always_comb begin
    if (lim_cfg_r == '0) begin
      limit = LW'(1);
    end else if (LW'(lim_cfg_r) > LW'(CAPACITY)) begin
      limit = LW'(CAPACITY);
    end else begin
      limit = LW'(lim_cfg_r);
    end
  end
  assign full = LW'(count_r) >= limit;

  // keys are unique, so at most one cell matches
  always_comb begin
    any_hit  = 1'b0;
    hit_pos  = '0;
    hit_val  = '0;
    tail_exp = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_hit  = any_hit | c_match[i];
      hit_pos  = hit_pos | (c_match[i] ? IW'(i) : '0);
      hit_val  = hit_val | (c_match[i] ? c_val[i] : '0);
      tail_exp = tail_exp | (c_tail[i] & c_exp[i]);
    end
  end

  assign head_val = (op_r == lruc_pkg::OP_INSERT && !hit_r) ? val_r : hval_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_row
    logic [KEY_BITS-1:0]   p_key, n_key;
    logic [VALUE_BITS-1:0] p_val, n_val;
    logic [TW-1:0]         p_stamp, n_stamp;
    logic                  p_valid, p_tail, n_valid;

    if (g == 0) begin : g_first
      assign p_key   = '0;
      assign p_val   = '0;
      assign p_stamp = '0;
      assign p_valid = 1'b0;
      assign p_tail  = 1'b0;
    end else begin : g_mid
      assign p_key   = c_key[g-1];
      assign p_val   = c_val[g-1];
      assign p_stamp = c_stamp[g-1];
      assign p_valid = c_valid[g-1];
      assign p_tail  = c_tail[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign n_key   = '0;
      assign n_val   = '0;
      assign n_stamp = '0;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_key   = c_key[g+1];
      assign n_val   = c_val[g+1];
      assign n_stamp = c_stamp[g+1];
      assign n_valid = c_valid[g+1];
    end

    lruc_cell #(
      .IDX        (g),
      .IW         (IW),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .pos        (pos_r),
      .look_key   (key_r),
      .now        (now_r),
      .ttl        (ttl_r),
      .head_key   (key_r),
      .head_val   (head_val),
      .prev_key   (p_key),
      .prev_val   (p_val),
      .prev_stamp (p_stamp),
      .prev_valid (p_valid),
      .prev_tail  (p_tail),
      .next_key   (n_key),
      .next_val   (n_val),
      .next_stamp (n_stamp),
      .next_valid (n_valid),
      .key        (c_key[g]),
      .val        (c_val[g]),
      .stamp      (c_stamp[g]),
      .valid      (c_valid[g]),
      .is_tail    (c_tail[g]),
      .match      (c_match[g]),
      .expired    (c_exp[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    removed_nxt   = removed_r;
    cmd.act       = lruc_pkg::ACT_HOLD;
    cmd.evict     = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    status_nxt    = status_r;
    vout_nxt      = vout_r;
    evicted_nxt   = evicted_r;
    rem_out_nxt   = rem_out_r;
    occ_nxt       = occ_r;
    case (state_r)
      S_IDLE: begin
        if (take_in) begin
          removed_nxt = '0;
          state_nxt = (lruc_pkg::op_t'(in_operation) == lruc_pkg::OP_EXPIRE) ? S_EXP : S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: begin
        if (out_free) begin
          status_nxt  = lruc_pkg::ST_OK;
          vout_nxt    = '0;
          evicted_nxt = 1'b0;
          rem_out_nxt = '0;
          case (op_r)
            lruc_pkg::OP_INSERT: begin
              if (hit_r) begin
                cmd.act    = lruc_pkg::ACT_PROMOTE;
                status_nxt = lruc_pkg::ST_DUP;
              end else begin
                cmd.act     = lruc_pkg::ACT_PUSH;
                cmd.evict   = full;
                evicted_nxt = full;
                if (!full) begin
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            lruc_pkg::OP_SEARCH: begin
              if (hit_r) begin
                cmd.act  = lruc_pkg::ACT_PROMOTE;
                vout_nxt = hval_r;
              end else begin
                status_nxt = lruc_pkg::ST_MISS;
              end
            end
            lruc_pkg::OP_DELETE: begin
              if (hit_r) begin
                cmd.act   = lruc_pkg::ACT_PULL;
                count_nxt = count_r - 1'b1;
              end else begin
                status_nxt = lruc_pkg::ST_MISS;
              end
            end
            default: ;
          endcase
          occ_nxt       = OW'(count_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EXP: begin
        // one tail entry checked per cycle
        if (tail_exp) begin
          cmd.act     = lruc_pkg::ACT_DROP;
          count_nxt   = count_r - 1'b1;
          removed_nxt = removed_r + 1'b1;
        end else if (out_free) begin
          status_nxt    = lruc_pkg::ST_OK;
          vout_nxt      = '0;
          evicted_nxt   = 1'b0;
          rem_out_nxt   = OW'(removed_r);
          occ_nxt       = OW'(count_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
      lim_cfg_r   <= LB'(16);
      ttl_r       <= TW'(3600);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (lruc_pkg::reg_idx_t'(cfg_index))
          lruc_pkg::REG_LIMIT: lim_cfg_r <= cfg_data[LB-1:0];
          lruc_pkg::REG_TTL:   ttl_r <= cfg_data[TW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      op_r  <= lruc_pkg::op_t'(in_operation);
      key_r <= in_key;
      val_r <= in_value;
      now_r <= in_now;
    end
    if (state_r == S_LOOK) begin
      hit_r  <= any_hit;
      pos_r  <= hit_pos;
      hval_r <= hit_val;
    end
    status_r  <= status_nxt;
    vout_r    <= vout_nxt;
    evicted_r <= evicted_nxt;
    rem_out_r <= rem_out_nxt;
    occ_r     <= occ_nxt;
  end

endmodule

// ----- src/lruc_cell.sv -----
// lruc_cell: one entry of the recency-ordered row (position 0 is most recent)
// depends on lruc_pkg; neighbours are wired up by lru_cache_with_ttl_expiry
module lruc_cell #(
  parameter int IDX        = 0,
  parameter int IW         = 4,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lruc_pkg::cell_cmd_t            cmd,
  input  logic [IW-1:0]                  pos,
  input  logic [KEY_BITS-1:0]            look_key,
  input  logic [lruc_pkg::TIME_BITS-1:0] now,
  input  logic [lruc_pkg::TIME_BITS-1:0] ttl,
  input  logic [KEY_BITS-1:0]            head_key,
  input  logic [VALUE_BITS-1:0]          head_val,
  input  logic [KEY_BITS-1:0]            prev_key,
  input  logic [VALUE_BITS-1:0]          prev_val,
  input  logic [lruc_pkg::TIME_BITS-1:0] prev_stamp,
  input  logic                           prev_valid,
  input  logic                           prev_tail,
  input  logic [KEY_BITS-1:0]            next_key,
  input  logic [VALUE_BITS-1:0]          next_val,
  input  logic [lruc_pkg::TIME_BITS-1:0] next_stamp,
  input  logic                           next_valid,
  output logic [KEY_BITS-1:0]            key,
  output logic [VALUE_BITS-1:0]          val,
  output logic [lruc_pkg::TIME_BITS-1:0] stamp,
  output logic                           valid,
  output logic                           is_tail,
  output logic                           match,
  output logic                           expired
);

  localparam logic [IW-1:0] MY_POS = IW'(IDX);

  logic [KEY_BITS-1:0]            key_r, key_nxt;
  logic [VALUE_BITS-1:0]          val_r, val_nxt;
  logic [lruc_pkg::TIME_BITS-1:0] stamp_r, stamp_nxt;
  logic                           valid_r, valid_nxt;
  logic [lruc_pkg::TIME_BITS-1:0] age;

  assign key     = key_r;
  assign val     = val_r;
  assign stamp   = stamp_r;
  assign valid   = valid_r;
  assign is_tail = valid_r & ~next_valid;
  assign match   = valid_r & (key_r == look_key);
  // stamps from the future count as age zero
  assign age     = (now >= stamp_r) ? (now - stamp_r) : '0;
  assign expired = age > ttl;

  always_comb begin
    key_nxt   = key_r;
    val_nxt   = val_r;
    stamp_nxt = stamp_r;
    valid_nxt = valid_r;
    case (cmd.act)
      lruc_pkg::ACT_PROMOTE: begin
        if (IDX == 0) begin
          key_nxt   = head_key;
          val_nxt   = head_val;
          stamp_nxt = now;
          valid_nxt = 1'b1;
        end else if (MY_POS <= pos) begin
          key_nxt   = prev_key;
          val_nxt   = prev_val;
          stamp_nxt = prev_stamp;
          valid_nxt = prev_valid;
        end
      end
      lruc_pkg::ACT_PUSH: begin
        if (IDX == 0) begin
          key_nxt   = head_key;
          val_nxt   = head_val;
          stamp_nxt = now;
          valid_nxt = 1'b1;
        end else begin
          key_nxt   = prev_key;
          val_nxt   = prev_val;
          stamp_nxt = prev_stamp;
          // the old tail falls off when evicting
          valid_nxt = prev_valid & ~(cmd.evict & prev_tail);
        end
      end
      lruc_pkg::ACT_PULL: begin
        if (MY_POS >= pos) begin
          key_nxt   = next_key;
          val_nxt   = next_val;
          stamp_nxt = next_stamp;
          valid_nxt = next_valid;
        end
      end
      lruc_pkg::ACT_DROP: valid_nxt = valid_r & ~is_tail;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    stamp_r <= stamp_nxt;
  end

endmodule

// ----- verif/lru_cache_with_ttl_expiry_test.sv -----
// testbench for lru_cache_with_ttl_expiry: random and directed cache operations checked
// against a behavioural lru/ttl predictor held in the testbench
// depends on lruc_pkg and the rtl of lru_cache_with_ttl_expiry
module lru_cache_with_ttl_expiry_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 16;
  localparam longint unsigned LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic        evicted;
    logic [4:0]  removed_count;
    logic [4:0]  occupancy;
  } cache_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [lruc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [lruc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [lruc_pkg::OP_BITS-1:0] in_operation = '0;
  logic [63:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic [31:0] in_now = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic [31:0] out_value_out;
  logic out_evicted;
  logic [4:0] out_removed_count;
  logic [4:0] out_occupancy;

  lru_cache_with_ttl_expiry uut (.*);

  // predictor state
  logic [63:0] line_key[CAP];
  logic [31:0] line_val[CAP];
  logic [31:0] line_stamp[CAP];
  bit          line_live[CAP];
  int unsigned line_rank[CAP];
  int unsigned live_count;
  logic [4:0]  limit_reg;
  logic [31:0] ttl_reg;

  cache_result_t awaited_results[$];
  int errors = 0;
  longint unsigned cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [31:0] clock_now = 0;
  logic [63:0] key_pool[8];

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    cache_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report("unexpected transfer, status", 32'(out_status), 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status)
          report("status", 32'(out_status), 32'(want.status));
        if (out_value_out !== want.value_out)
          report("value_out", out_value_out, want.value_out);
        if (out_evicted !== want.evicted)
          report("evicted", 32'(out_evicted), 32'(want.evicted));
        if (out_removed_count !== want.removed_count)
          report("removed_count", 32'(out_removed_count), 32'(want.removed_count));
        if (out_occupancy !== want.occupancy)
          report("occupancy", 32'(out_occupancy), 32'(want.occupancy));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int find_line(logic [63:0] k);
    for (int i = 0; i < CAP; i++)
      if (line_live[i] && line_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int oldest_line();
    int best;
    best = -1;
    for (int i = 0; i < CAP; i++)
      if (line_live[i] && (best < 0 || line_rank[i] > line_rank[best])) best = i;
    return best;
  endfunction

  function automatic void make_recent(int s);
    int unsigned r;
    r = line_rank[s];
    for (int i = 0; i < CAP; i++)
      if (line_live[i] && line_rank[i] < r) line_rank[i]++;
    line_rank[s] = 0;
  endfunction

  function automatic void drop_line(int s);
    int unsigned r;
    r = line_rank[s];
    line_live[s] = 0;
    line_rank[s] = 0;
    for (int i = 0; i < CAP; i++)
      if (line_live[i] && line_rank[i] > r) line_rank[i]--;
    if (live_count > 0) live_count--;
  endfunction

  function automatic cache_result_t predict_cache(lruc_pkg::op_t op, logic [63:0] k,
                                                  logic [31:0] v, logic [31:0] now);
    cache_result_t res;
    int s, old;
    int unsigned lim;
    logic [31:0] age;
    res = '0;
    lim = (limit_reg == 0) ? 1 : (limit_reg > CAP) ? CAP : limit_reg;
    s = find_line(k);
    case (op)
      lruc_pkg::OP_INSERT: begin
        if (s >= 0) begin
          make_recent(s);
          line_stamp[s] = now;
          res.status = lruc_pkg::ST_DUP;
        end else begin
          if (live_count >= lim) begin
            old = oldest_line();
            if (old >= 0) begin
              drop_line(old);
              res.evicted = 1;
            end
          end
          s = -1;
          for (int i = 0; i < CAP; i++)
            if (!line_live[i] && s < 0) s = i;
          if (s >= 0) begin
            for (int i = 0; i < CAP; i++)
              if (line_live[i]) line_rank[i]++;
            line_key[s] = k;
            line_val[s] = v;
            line_stamp[s] = now;
            line_live[s] = 1;
            line_rank[s] = 0;
            live_count++;
          end
        end
      end
      lruc_pkg::OP_SEARCH: begin
        if (s >= 0) begin
          make_recent(s);
          line_stamp[s] = now;
          res.value_out = line_val[s];
        end else res.status = lruc_pkg::ST_MISS;
      end
      lruc_pkg::OP_DELETE: begin
        if (s >= 0) drop_line(s);
        else res.status = lruc_pkg::ST_MISS;
      end
      default: begin
        while (live_count > 0) begin
          old = oldest_line();
          if (old < 0) break;
          age = (now >= line_stamp[old]) ? now - line_stamp[old] : 32'd0;
          if (age > ttl_reg) begin
            drop_line(old);
            res.removed_count++;
          end else break;
        end
      end
    endcase
    res.occupancy = live_count[4:0];
    return res;
  endfunction

  // valid stays high after a transfer until the sender idles or stops
  task automatic send_item(lruc_pkg::op_t op, logic [63:0] k, logic [31:0] v,
                           logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_key <= k;
    in_value <= v;
    in_now <= now;
    awaited_results.push_back(predict_cache(op, k, v, now));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(lruc_pkg::reg_idx_t idx, logic [31:0] data);
    wait_drained();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == lruc_pkg::REG_LIMIT) limit_reg = data[4:0];
    else ttl_reg = data;
  endtask

  task automatic test_directed();
    send_item(lruc_pkg::OP_SEARCH, 64'h0, 32'h0, 32'd0);
    send_item(lruc_pkg::OP_DELETE, 64'h5, 32'h0, 32'd0);
    send_item(lruc_pkg::OP_EXPIRE, 64'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(lruc_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd10);
    send_item(lruc_pkg::OP_INSERT, 64'h0, 32'h0, 32'd20);
    send_item(lruc_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234, 32'd30);
    send_item(lruc_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'd40);
    send_item(lruc_pkg::OP_SEARCH, 64'h1, 32'h0, 32'd40);
    send_item(lruc_pkg::OP_EXPIRE, 64'h0, 32'h0, 32'd5);
    send_item(lruc_pkg::OP_EXPIRE, 64'h0, 32'h0, 32'd3620);
    send_item(lruc_pkg::OP_EXPIRE, 64'h0, 32'h0, 32'd3700);
    send_item(lruc_pkg::OP_DELETE, 64'h0, 32'h0, 32'd0);
    send_item(lruc_pkg::OP_DELETE, 64'h0, 32'h0, 32'd0);
    for (int i = 0; i < 18; i++)
      send_item(lruc_pkg::OP_INSERT, 64'(i) << 40 | 64'(i), 32'(i * 7), 32'(100 + i));
    send_item(lruc_pkg::OP_EXPIRE, 64'h0, 32'h0, 32'hFFFF_FFFF);
  endtask

  // limit changes, including lowering it below occupancy and the out-of-range codes
  task automatic test_limits();
    logic [4:0] lims[6] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd3, 5'd16};
    foreach (lims[j]) begin
      write_reg(lruc_pkg::REG_LIMIT, {27'd0, lims[j]});
      for (int i = 0; i < 6; i++)
        send_item(lruc_pkg::op_t'($urandom_range(3)), {60'd0, 4'($urandom_range(9))},
                  $urandom, 32'(200 + i));
    end
  endtask

  task automatic random_phase(int count);
    lruc_pkg::op_t op;
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      // time mostly advances, sometimes jumps to a random value
      if ($urandom_range(19) == 0) clock_now = $urandom;
      else clock_now = clock_now + $urandom_range(30);
      op = lruc_pkg::op_t'($urandom_range(3));
      if ($urandom_range(9) < 8) k = key_pool[$urandom_range(7)];
      else k = {$urandom, $urandom};
      if ($urandom_range(2) == 0) op = lruc_pkg::OP_INSERT;
      send_item(op, k, $urandom, clock_now);
    end
  endtask

  task automatic test_random();
    logic [31:0] ttls[5] = '{32'd0, 32'd40, 32'd3600, 32'hFFFF_FFFF, 32'd8};
    int phases[4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{19, 19}};
    int k;
    k = 0;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phases[p][0];
      recv_stall_pct = phases[p][1];
      for (int t = 0; t < 2; t++) begin
        write_reg(lruc_pkg::REG_TTL, ttls[k % 5]);
        write_reg(lruc_pkg::REG_LIMIT,
                  (k % 3 == 0) ? 32'd16 : 32'($urandom_range(1, 16)));
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        random_phase(210);
        k++;
      end
    end
  endtask

  // sender holds off until every result is back, then carries on
  task automatic test_pause();
    send_idle_pct = 0;
    recv_stall_pct = 30;
    random_phase(20);
    in_valid <= 0;
    while (awaited_results.size() != 0) @(posedge clk);
    random_phase(20);
  endtask

  initial begin
    limit_reg = 5'd16;
    ttl_reg = 32'd3600;
    live_count = 0;
    for (int i = 0; i < CAP; i++) begin
      line_live[i] = 0;
      line_rank[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_random();
    test_pause();
    wait_drained();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- sim.f -----
src/lruc_pkg.sv
src/lruc_cell.sv
src/lru_cache_with_ttl_expiry.sv
verif/lru_cache_with_ttl_expiry_test.sv
